// ===== hw/rtl/lmgs_pkg.sv =====
`default_nettype none
package lmgs_pkg;

    localparam int ROWS    = 8;
    localparam int PLANES  = 3;
    localparam int ROW_W   = $clog2(ROWS);
    localparam int COL_W   = 8;
    localparam int LINE_W  = PLANES * COL_W;
    localparam int PLANE_W = $clog2(PLANES);

    localparam logic [15:0] FRAME_LEN_RST = 16'd195;

    // function codes of an input word
    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    typedef struct packed {
        logic       func;
        logic [2:0] pixel_x;
        logic [2:0] pixel_y;
        logic [1:0] pixel_level;
        logic [7:0] button_pins;
    } t_in_word;

    typedef struct packed {
        logic [7:0]  column_drive;
        logic [7:0]  row_drive;
        logic        frame_tick;
        logic [7:0]  buttons_down;
        logic [7:0]  buttons_new;
        logic [15:0] entropy_seed;
    } t_out_word;

    // one row of the plane store: plane 2 in the top byte, plane 0 at the bottom
    typedef struct packed {
        logic              en;
        logic [ROW_W-1:0]  addr;
        logic [LINE_W-1:0] data;
    } t_line_wr;

    // column wiring of the matrix
    function automatic logic [COL_W-1:0] col_perm(input logic [2:0] x);
        logic [COL_W-1:0] m;
        case (x)
            3'd0:    m = 8'h04;
            3'd1:    m = 8'h02;
            3'd2:    m = 8'h40;
            3'd3:    m = 8'h01;
            3'd4:    m = 8'h08;
            3'd5:    m = 8'h80;
            3'd6:    m = 8'h20;
            default: m = 8'h10;
        endcase
        return m;
    endfunction

    // row wiring of the matrix
    function automatic logic [COL_W-1:0] row_perm(input logic [ROW_W-1:0] r);
        logic [COL_W-1:0] m;
        case (r)
            3'd0:    m = 8'h04;
            3'd1:    m = 8'h80;
            3'd2:    m = 8'h40;
            3'd3:    m = 8'h08;
            3'd4:    m = 8'h20;
            3'd5:    m = 8'h10;
            3'd6:    m = 8'h02;
            default: m = 8'h01;
        endcase
        return m;
    endfunction

    // brightness slot to plane: 0 -> 0, 1..2 -> 1, 3..7 -> 2
    function automatic logic [PLANE_W-1:0] plane_of(input logic [2:0] sel);
        logic [PLANE_W-1:0] p;
        if (sel >= 3'd3) begin
            p = 2'd2;
        end else if (sel >= 3'd1) begin
            p = 2'd1;
        end else begin
            p = 2'd0;
        end
        return p;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/led_matrix_grayscale_scanner.sv =====
`default_nettype none
// 8x8 led matrix scanner with four grey levels and button sampling
//
// input channel (i_in_valid / o_in_ready / i_in_word) takes one word per
//   cycle while ready: func write stores a pixel level as three bit planes,
//   no result; func tick advances the scan and gives exactly one output word
// output channel (o_out_valid / i_out_ready / o_out_word) carries the column
//   byte, the active-low row select, the frame tick, button state and seed
// a tick's word: plane store read into the read stage, then output register
// throughput: one word per cycle unless the output stalls, set by the plane
//   store line read-modify-write; a write to the line being read is forwarded
// stall: the output register holds its word; one more word waits in the
//   read stage, then o_in_ready drops until the receiver takes the word
// reset (i_rst_n low, synchronous): counters, button history and seed clear,
//   frame_length returns to 195, all lines read dark until written
// i_cfg_wr_en / i_cfg_wr_data write frame_length at once; the user must do
//   so only while idle, which the block itself does not enforce
module led_matrix_grayscale_scanner (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire lmgs_pkg::t_in_word  i_in_word,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output lmgs_pkg::t_out_word      o_out_word,
    input  wire logic                i_cfg_wr_en,
    input  wire logic [15:0]         i_cfg_wr_data
);
    import lmgs_pkg::*;

    // configuration and scan state
    logic [15:0] r_frame_len;
    logic [7:0]  r_scan, n_scan;
    logic [15:0] r_tick, n_tick;
    logic [7:0]  r_last_btn;
    logic [15:0] r_seed, n_seed;

    // read stage
    logic               r_s1_valid;
    t_in_word           r_s1_word;
    logic [PLANE_W-1:0] r_s1_plane;
    t_out_word          r_s1_res;
    t_out_word          n_s1_res;
    t_out_word          s1_out;

    // forwarding of a line written while the next word reads it
    logic              r_fwd;
    logic [LINE_W-1:0] r_fwd_data;

    // output register
    logic      r_out_valid;
    t_out_word r_out_word;

    logic              in_acc;
    logic              s1_adv;
    logic              s1_is_wr;
    logic [ROW_W-1:0]  rd_addr;
    logic [LINE_W-1:0] mem_rd;
    logic [LINE_W-1:0] line_cur;
    logic [LINE_W-1:0] line_new;
    t_line_wr          line_wr;
    logic              frame;
    logic [7:0]        down;
    logic [7:0]        fresh;
    logic [15:0]       tick_inc;
    logic [COL_W-1:0]  pix_mask;

    // handshakes: a write word in the read stage always retires
    assign s1_is_wr   = r_s1_word.func == FUNC_WRITE;
    assign s1_adv     = r_s1_valid && (s1_is_wr || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_acc     = i_in_valid && o_in_ready;

    // scan counter moves on at accept so the row read can be issued at once
    assign n_scan  = r_scan + 8'd1;
    assign rd_addr = (i_in_word.func == FUNC_WRITE) ? i_in_word.pixel_y
                                                    : n_scan[ROW_W-1:0];

    // tick bookkeeping, all on the accepted word
    always_comb begin
        tick_inc = r_tick + 16'd1;
        frame    = tick_inc >= r_frame_len;
        n_tick   = frame ? 16'd0 : tick_inc;
        down     = ~i_in_word.button_pins;
        fresh    = down & ~r_last_btn;
        // seed * 31 as a shift and subtract
        n_seed   = (fresh != 8'd0) ? ({r_seed[10:0], 5'd0} - r_seed + n_tick) : r_seed;

        n_s1_res              = '0;
        n_s1_res.row_drive    = ~row_perm(n_scan[ROW_W-1:0]);
        n_s1_res.frame_tick   = frame;
        n_s1_res.buttons_down = down;
        n_s1_res.buttons_new  = fresh;
        n_s1_res.entropy_seed = n_seed;
    end

    // plane store line as seen by the read stage
    assign line_cur = r_fwd ? r_fwd_data : mem_rd;

    // pixel write: set or clear the column bit in each plane
    always_comb begin
        pix_mask = col_perm(r_s1_word.pixel_x);
        line_new = line_cur;
        for (int b = 0; b < PLANES; b++) begin
            if (r_s1_word.pixel_level > b[1:0]) begin
                line_new[b*COL_W +: COL_W] = line_cur[b*COL_W +: COL_W] | pix_mask;
            end else begin
                line_new[b*COL_W +: COL_W] = line_cur[b*COL_W +: COL_W] & ~pix_mask;
            end
        end
        line_wr.en   = s1_adv && s1_is_wr;
        line_wr.addr = r_s1_word.pixel_y;
        line_wr.data = line_new;
    end

    // tick word leaving the read stage with its column byte
    always_comb begin
        s1_out              = r_s1_res;
        s1_out.column_drive = line_cur[r_s1_plane*COL_W +: COL_W];
    end

    lmgs_plane_mem u_plane_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (line_wr),
        .i_rd_en   (in_acc),
        .i_rd_addr (rd_addr),
        .o_rd_data (mem_rd)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_len <= FRAME_LEN_RST;
            r_scan      <= '0;
            r_tick      <= '0;
            r_last_btn  <= '0;
            r_seed      <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fwd       <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_frame_len <= i_cfg_wr_data;
            end
            if (in_acc && i_in_word.func == FUNC_TICK) begin
                r_scan     <= n_scan;
                r_tick     <= n_tick;
                r_last_btn <= down;
                r_seed     <= n_seed;
            end
            if (in_acc) begin
                r_s1_valid <= 1'b1;
                r_fwd      <= line_wr.en && (line_wr.addr == rd_addr);
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv && !s1_is_wr) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_word  <= i_in_word;
            r_s1_plane <= plane_of(n_scan[5:3]);
            r_s1_res   <= n_s1_res;
            r_fwd_data <= line_new;
        end
        if (s1_adv && !s1_is_wr) begin
            r_out_word <= s1_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
`default_nettype wire

// ===== hw/rtl/lmgs_plane_mem.sv =====
`default_nettype none
module lmgs_plane_mem (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire lmgs_pkg::t_line_wr        i_wr,
    input  wire logic                      i_rd_en,
    input  wire logic [lmgs_pkg::ROW_W-1:0] i_rd_addr,
    output logic [lmgs_pkg::LINE_W-1:0]    o_rd_data
);
    import lmgs_pkg::*;

    logic [LINE_W-1:0] r_mem [ROWS];
    logic [ROWS-1:0]   r_line_vld;
    logic [LINE_W-1:0] r_rd_raw;
    logic              r_rd_vld;

    // storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_raw <= r_mem[i_rd_addr];
        end
    end

    // a line never written reads as dark
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_vld <= '0;
            r_rd_vld   <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_line_vld[i_wr.addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_line_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_raw : '0;

endmodule
`default_nettype wire
